>>> rtl/core/wbpp_pkg.sv
// ---------------------------------------------------------------------------
// wbpp_pkg - shared types and constants of the boundary peak picker
// Register map, weight format and the control words passed between the
// sequencer and its arithmetic and compare units.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbpp_pkg;

  // weight format: unsigned Q0.16
  localparam int WEIGHT_W  = 16;
  // window span register width
  localparam int SPAN_W    = 4;
  // config port widths
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  // weighted sum is brought back to Q0 and halved
  localparam int SUM_SHIFT = WEIGHT_W + 1;

  // register reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONSET_RST = 16'd32768;
  localparam logic [WEIGHT_W-1:0] WEIGHT_PITCH_RST = 16'd16384;
  localparam logic [WEIGHT_W-1:0] WEIGHT_REST_RST  = 16'd16384;
  localparam logic [SPAN_W-1:0]   WINDOW_SPAN_RST  = 4'd4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_ONSET = 2'd0,
    REG_WEIGHT_PITCH = 2'd1,
    REG_WEIGHT_REST  = 2'd2,
    REG_WINDOW_SPAN  = 2'd3
  } cfg_reg_t;

  // term picked by the shared multiplier
  typedef enum logic [1:0] {
    TERM_ONSET = 2'd0,
    TERM_PITCH = 2'd1,
    TERM_REST  = 2'd2
  } term_sel_t;

  // multiply-accumulate control word
  typedef struct packed {
    logic      load;
    logic      clear;
    logic      mul_en;
    logic      acc_en;
    term_sel_t sel;
  } mac_ctl_t;

  // window compare control word
  typedef struct packed {
    logic load_center;
    logic compare;
  } cmp_ctl_t;

endpackage

>>> rtl/core/wbpp_ram.sv
// ---------------------------------------------------------------------------
// wbpp_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbpp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/wbpp_mac.sv
// ---------------------------------------------------------------------------
// wbpp_mac - shared multiplier and accumulator
// Holds the three strengths of a word and forms the weighted sum one
// product per cycle, with a register between multiplier and adder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbpp_mac #(
  parameter int STRENGTH_BITS = 16
) (
  input  logic                                        clk,
  input  wbpp_pkg::mac_ctl_t                          ctl,
  input  logic [STRENGTH_BITS-1:0]                    pitch_in,
  input  logic [STRENGTH_BITS-1:0]                    onset_in,
  input  logic [STRENGTH_BITS-1:0]                    rest_in,
  input  logic [wbpp_pkg::WEIGHT_W-1:0]               wt_onset,
  input  logic [wbpp_pkg::WEIGHT_W-1:0]               wt_pitch,
  input  logic [wbpp_pkg::WEIGHT_W-1:0]               wt_rest,
  output logic [STRENGTH_BITS+wbpp_pkg::WEIGHT_W+1:0] acc
);

  localparam int PROD_W = STRENGTH_BITS + wbpp_pkg::WEIGHT_W;
  localparam int ACC_W  = PROD_W + 2;

  logic [STRENGTH_BITS-1:0]      pitch_r;
  logic [STRENGTH_BITS-1:0]      onset_r;
  logic [STRENGTH_BITS-1:0]      rest_r;
  logic [STRENGTH_BITS-1:0]      op_s;
  logic [wbpp_pkg::WEIGHT_W-1:0] op_w;
  logic [PROD_W-1:0]             prod_r;
  logic [ACC_W-1:0]              acc_r;

  // operand select
  always_comb begin
    unique case (ctl.sel)
      wbpp_pkg::TERM_ONSET: begin
        op_s = onset_r;
        op_w = wt_onset;
      end
      wbpp_pkg::TERM_PITCH: begin
        op_s = pitch_r;
        op_w = wt_pitch;
      end
      wbpp_pkg::TERM_REST: begin
        op_s = rest_r;
        op_w = wt_rest;
      end
      default: begin
        op_s = '0;
        op_w = '0;
      end
    endcase
  end

  // operand capture, product register, accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pitch_r <= pitch_in;
      onset_r <= onset_in;
      rest_r  <= rest_in;
    end
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(op_s) * PROD_W'(op_w);
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

>>> rtl/core/wbpp_cmp.sv
// ---------------------------------------------------------------------------
// wbpp_cmp - window compare unit
// Holds the value under test and clears the peak flag when any value
// read from the window is larger.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbpp_cmp #(
  parameter int WIDTH = 17
) (
  input  logic               clk,
  input  wbpp_pkg::cmp_ctl_t ctl,
  input  logic [WIDTH-1:0]   rd_data,
  output logic [WIDTH-1:0]   center,
  output logic               peak
);

  logic [WIDTH-1:0] center_r;
  logic             peak_r;

  // center capture and running peak test
  always_ff @(posedge clk) begin
    if (ctl.load_center) begin
      center_r <= rd_data;
      peak_r   <= 1'b1;
    end else if (ctl.compare && (center_r < rd_data)) begin
      peak_r <= 1'b0;
    end
  end

  assign center = center_r;
  assign peak   = peak_r;

endmodule

>>> rtl/core/weighted_boundary_peak_picker_top.sv
// ---------------------------------------------------------------------------
// weighted_boundary_peak_picker_top - boundary peak picker
// Combines three boundary strengths per note position and marks positions
// that are local maxima within a window of +/- span positions.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one word per note position (three strengths, final_note flag).
//   out_* : one word per reported position, oldest first. A position is
//           reported once span later positions have arrived; a word with
//           final_note set flushes the rest of the part, the last result
//           carrying out_last_of_part.
//   cfg_* : weights and window span, written while the block is idle.
// Timing: in_ready is high only between words. Each result reads up to
//   2*span+1 window entries. The time a word takes is set by the single
//   read port of the window RAM, one window entry per cycle, and the
//   shared multiplier, one product per cycle.
// Reset: weights and span return to their defaults, the part starts empty,
//   no result is pending. The window RAM is not cleared.
// Stall: a result waits in the output register; the sequencer holds a further
//   result until it is taken, and the next word may be accepted while the last one waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_boundary_peak_picker_top #(
  parameter int MAX_SPAN      = 8,
  parameter int STRENGTH_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [STRENGTH_BITS-1:0]          in_pitch_strength,
  input  logic [STRENGTH_BITS-1:0]          in_onset_strength,
  input  logic [STRENGTH_BITS-1:0]          in_rest_strength,
  input  logic                              in_final_note,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [STRENGTH_BITS:0]            out_combined_strength,
  output logic                              out_is_boundary,
  output logic                              out_last_of_part,
  // config port
  input  logic                              cfg_we,
  input  logic [wbpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbpp_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int VAL_W  = STRENGTH_BITS + 1;
  localparam int ACC_W  = STRENGTH_BITS + wbpp_pkg::WEIGHT_W + 2;
  localparam int WIN_D  = 2 * MAX_SPAN + 1;
  localparam int AW     = $clog2(WIN_D);
  localparam int RING_D = 2 ** AW;
  localparam int CW     = $clog2(MAX_SPAN + 2);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL    = 8'b0000_0010,
    ST_WRITE  = 8'b0000_0100,
    ST_CHECK  = 8'b0000_1000,
    ST_START  = 8'b0001_0000,
    ST_CENTER = 8'b0010_0000,
    ST_SCAN   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  // config registers
  logic [wbpp_pkg::WEIGHT_W-1:0] w_onset_r, w_pitch_r, w_rest_r;
  logic [wbpp_pkg::SPAN_W-1:0]   win_span_r;

  // sequencer state
  state_t          state_r, state_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   items_r, items_nxt;
  logic [CW-1:0]   emit_r, emit_nxt;
  logic            final_r, final_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   hi_r, hi_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_comb_r;
  logic            out_bnd_r;
  logic            out_last_r;
  logic            out_load;

  // datapath links
  wbpp_pkg::mac_ctl_t mac_ctl;
  wbpp_pkg::cmp_ctl_t cmp_ctl;
  logic [ACC_W-1:0]   acc;
  logic [VAL_W-1:0]   value;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [VAL_W-1:0]   ram_rdata;
  logic [VAL_W-1:0]   center;
  logic               peak;

  // window geometry
  logic [CW-1:0] span;
  logic [CW-1:0] at;
  logic [CW-1:0] right;
  logic [CW-1:0] left;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic          due;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_onset_r  <= wbpp_pkg::WEIGHT_ONSET_RST;
      w_pitch_r  <= wbpp_pkg::WEIGHT_PITCH_RST;
      w_rest_r   <= wbpp_pkg::WEIGHT_REST_RST;
      win_span_r <= wbpp_pkg::WINDOW_SPAN_RST;
    end else if (cfg_we) begin
      unique case (wbpp_pkg::cfg_reg_t'(cfg_index))
        wbpp_pkg::REG_WEIGHT_ONSET: w_onset_r  <= cfg_wdata;
        wbpp_pkg::REG_WEIGHT_PITCH: w_pitch_r  <= cfg_wdata;
        wbpp_pkg::REG_WEIGHT_REST:  w_rest_r   <= cfg_wdata;
        wbpp_pkg::REG_WINDOW_SPAN:  win_span_r <= cfg_wdata[wbpp_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiply-accumulate
  wbpp_mac #(
    .STRENGTH_BITS (STRENGTH_BITS)
  ) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .pitch_in (in_pitch_strength),
    .onset_in (in_onset_strength),
    .rest_in  (in_rest_strength),
    .wt_onset (w_onset_r),
    .wt_pitch (w_pitch_r),
    .wt_rest  (w_rest_r),
    .acc      (acc)
  );

  // weighted sum back to Q0, halved
  assign value = acc[ACC_W-1:wbpp_pkg::SUM_SHIFT];

  // window ring, newest position at head
  wbpp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RING_D)
  ) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // window compare
  wbpp_cmp #(
    .WIDTH (VAL_W)
  ) u_cmp (
    .clk     (clk),
    .ctl     (cmp_ctl),
    .rd_data (ram_rdata),
    .center  (center),
    .peak    (peak)
  );

  // effective span and window bounds of the oldest pending position
  always_comb begin
    if (int'(win_span_r) > MAX_SPAN) begin
      span = CW'(MAX_SPAN);
    end else begin
      span = CW'(win_span_r);
    end
    at    = items_r - CW'(1);
    right = (span < at) ? span : at;
    left  = (span < emit_r) ? span : emit_r;
    lo    = AW'(at) - AW'(right);
    hi    = AW'(at) + AW'(left);
    due   = (items_r > span) || (final_r && (items_r != '0));
  end

  // window read address
  always_comb begin
    unique case (state_r)
      ST_START:  ram_raddr = head_r - AW'(at);
      ST_CENTER: ram_raddr = head_r - j_r;
      ST_SCAN:   ram_raddr = head_r - (j_r + AW'(1));
      default:   ram_raddr = head_r;
    endcase
  end

  assign ram_waddr = head_r + AW'(1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    items_nxt     = items_r;
    emit_nxt      = emit_r;
    final_nxt     = final_r;
    j_nxt         = j_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    mac_ctl       = '0;
    cmp_ctl       = '0;
    ram_we        = 1'b0;

    // result taken by the receiver
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mac_ctl.load = 1'b1;
          final_nxt    = in_final_note;
          cnt_nxt      = '0;
          state_nxt    = ST_MUL;
        end
      end
      // three products, one per cycle, then the last add
      ST_MUL: begin
        mac_ctl.clear  = (cnt_r == 2'd0);
        mac_ctl.acc_en = (cnt_r != 2'd0);
        mac_ctl.mul_en = (cnt_r != 2'd3);
        unique case (cnt_r)
          2'd0:    mac_ctl.sel = wbpp_pkg::TERM_ONSET;
          2'd1:    mac_ctl.sel = wbpp_pkg::TERM_PITCH;
          default: mac_ctl.sel = wbpp_pkg::TERM_REST;
        endcase
        if (cnt_r == 2'd3) begin
          state_nxt = ST_WRITE;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      // push the new value into the window
      ST_WRITE: begin
        ram_we   = 1'b1;
        head_nxt = head_r + AW'(1);
        if (items_r < CW'(MAX_SPAN + 1)) begin
          items_nxt = items_r + CW'(1);
        end
        state_nxt = ST_CHECK;
      end
      // release due positions, restart the part after the final one
      ST_CHECK: begin
        if (due) begin
          state_nxt = ST_START;
        end else begin
          if (final_r) begin
            items_nxt = '0;
            emit_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        j_nxt     = lo;
        hi_nxt    = hi;
        state_nxt = ST_CENTER;
      end
      ST_CENTER: begin
        cmp_ctl.load_center = 1'b1;
        state_nxt           = ST_SCAN;
      end
      // one window entry per cycle
      ST_SCAN: begin
        cmp_ctl.compare = 1'b1;
        if (j_r == hi_r) begin
          state_nxt = ST_EMIT;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      // hand the result to the output register
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          items_nxt     = items_r - CW'(1);
          if (emit_r < CW'(MAX_SPAN)) begin
            emit_nxt = emit_r + CW'(1);
          end
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      items_r     <= '0;
      emit_r      <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      items_r     <= items_nxt;
      emit_r      <= emit_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window bounds and output word
  always_ff @(posedge clk) begin
    j_r  <= j_nxt;
    hi_r <= hi_nxt;
    if (out_load) begin
      out_comb_r <= center;
      out_bnd_r  <= peak;
      out_last_r <= final_r && (at == '0);
    end
  end

  assign in_ready              = (state_r == ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_combined_strength = out_comb_r;
  assign out_is_boundary       = out_bnd_r;
  assign out_last_of_part      = out_last_r;

endmodule

>>> rtl/core/wbpp_checker.sv
// ---------------------------------------------------------------------------
// wbpp_checker - port level checks of the boundary peak picker
// Watches the top level ports and is bound to every instance of it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbpp_checker #(
  parameter int STRENGTH_BITS = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STRENGTH_BITS:0]   out_combined_strength,
  input logic                     out_is_boundary,
  input logic                     out_last_of_part
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_combined_strength)
      && $stable(out_is_boundary) && $stable(out_last_of_part))
    else $error("result word changed while stalled");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending or input blocked after reset");

  // an accepted word keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // no result appears in the cycle right after an accepted word
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result produced before arithmetic finished");

endmodule

bind weighted_boundary_peak_picker_top wbpp_checker #(
  .STRENGTH_BITS (STRENGTH_BITS)
) u_wbpp_checker (.*);

>>> test/weighted_boundary_peak_picker_top_tb.sv
// ---------------------------------------------------------------------------
// weighted_boundary_peak_picker_top_tb - self-checking bench for the peak picker
// Walks a short table of directed words and register writes, then runs random
// parts under new weights and spans. Every word accepted on the input side is
// fed to a cycle-free predictor of the weighted sum and windowed peak test.
// Each result word is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_boundary_peak_picker_top_tb;

  localparam int MAX_SPAN      = 8;
  localparam int SB            = 16;
  localparam int WIN_DEPTH     = 2 * MAX_SPAN + 1;
  localparam int SUM_W         = 2 * SB + 2;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 3000;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_NOTES  = 205;
  localparam int CALM_NOTES    = 30;

  typedef enum logic {
    STEP_NOTE  = 1'b0,
    STEP_WRITE = 1'b1
  } step_kind_t;

  typedef struct packed {
    logic [SB:0] strength;
    logic        boundary;
    logic        last;
  } mark_t;

  typedef struct packed {
    step_kind_t                   kind;
    wbpp_pkg::cfg_reg_t           reg_idx;
    logic [wbpp_pkg::CFG_W-1:0]   value;
    logic [SB-1:0]                pitch;
    logic [SB-1:0]                onset;
    logic [SB-1:0]                rest;
    logic                         final_note;
    logic                         has_mark;
    mark_t                        mark;
  } step_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [SB-1:0]                  in_pitch_strength;
  logic [SB-1:0]                  in_onset_strength;
  logic [SB-1:0]                  in_rest_strength;
  logic                           in_final_note;
  logic                           out_valid;
  logic                           out_ready;
  logic [SB:0]                    out_combined_strength;
  logic                           out_is_boundary;
  logic                           out_last_of_part;
  logic                           cfg_we;
  logic [wbpp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wbpp_pkg::CFG_W-1:0]     cfg_wdata;

  // predictor state: settings and the window of combined values, newest first
  logic [wbpp_pkg::WEIGHT_W-1:0] w_onset  = wbpp_pkg::WEIGHT_ONSET_RST;
  logic [wbpp_pkg::WEIGHT_W-1:0] w_pitch  = wbpp_pkg::WEIGHT_PITCH_RST;
  logic [wbpp_pkg::WEIGHT_W-1:0] w_rest   = wbpp_pkg::WEIGHT_REST_RST;
  logic [wbpp_pkg::SPAN_W-1:0]   span_set = wbpp_pkg::WINDOW_SPAN_RST;
  logic [SB:0]                   win_vals [WIN_DEPTH];
  int                            pending_cnt  = 0;
  int                            reported_cnt = 0;
  mark_t                         awaited_marks [$];

  // directed stimulus table
  step_t plan [$];

  // bookkeeping shared by the stimulus and result sides
  int  err_cnt       = 0;
  int  notes_sent    = 0;
  int  parts_closed  = 0;
  int  marks_checked = 0;
  int  writes_done   = 0;
  bit  settled       = 1'b1;
  bit  calm          = 1'b0;
  bit  long_hold_req = 1'b0;

  weighted_boundary_peak_picker_top #(
    .MAX_SPAN      (MAX_SPAN),
    .STRENGTH_BITS (SB)
  ) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_pitch_strength     (in_pitch_strength),
    .in_onset_strength     (in_onset_strength),
    .in_rest_strength      (in_rest_strength),
    .in_final_note         (in_final_note),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_combined_strength (out_combined_strength),
    .out_is_boundary       (out_is_boundary),
    .out_last_of_part      (out_last_of_part),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // append to the queues
  function automatic void enqueue_mark(input mark_t m);
    awaited_marks.insert(awaited_marks.size(), m);
  endfunction

  function automatic void add_step(input step_t s);
    plan.insert(plan.size(), s);
  endfunction

  // register write as seen by the predictor
  function automatic void apply_write(input wbpp_pkg::cfg_reg_t idx,
                                      input logic [wbpp_pkg::CFG_W-1:0] val);
    case (idx)
      wbpp_pkg::REG_WEIGHT_ONSET: w_onset = val[wbpp_pkg::WEIGHT_W-1:0];
      wbpp_pkg::REG_WEIGHT_PITCH: w_pitch = val[wbpp_pkg::WEIGHT_W-1:0];
      wbpp_pkg::REG_WEIGHT_REST:  w_rest  = val[wbpp_pkg::WEIGHT_W-1:0];
      wbpp_pkg::REG_WINDOW_SPAN:  span_set = val[wbpp_pkg::SPAN_W-1:0];
      default: ;
    endcase
  endfunction

  // combine one note position, then release every position now due
  function automatic int predict_marks(input logic [SB-1:0] p, o, r, input logic f);
    logic [SUM_W-1:0] sum;
    logic [SB:0]      c;
    logic             peak;
    int               span_eff, at, right, left, i, n;
    // operands widen to the sum's width before multiplying
    sum = o * w_onset + p * w_pitch + r * w_rest;
    span_eff = (span_set > MAX_SPAN) ? MAX_SPAN : int'(span_set);
    n = 0;
    for (i = WIN_DEPTH - 1; i > 0; i--) win_vals[i] = win_vals[i-1];
    win_vals[0] = sum[SB+wbpp_pkg::SUM_SHIFT:wbpp_pkg::SUM_SHIFT];
    if (pending_cnt < MAX_SPAN + 1) pending_cnt++;
    while (pending_cnt > span_eff || (f && pending_cnt > 0)) begin
      at = pending_cnt - 1;
      c = win_vals[at];
      right = (span_eff < at) ? span_eff : at;
      left = (span_eff < reported_cnt) ? span_eff : reported_cnt;
      peak = 1'b1;
      // later positions, clipped at the newest one
      for (i = 1; i <= right; i++)
        if (c < win_vals[at-i]) peak = 1'b0;
      // earlier positions of this part
      for (i = 1; i <= left; i++)
        if (at + i < WIN_DEPTH && c < win_vals[at+i]) peak = 1'b0;
      enqueue_mark('{strength: c, boundary: peak, last: (f && at == 0)});
      n++;
      pending_cnt--;
      if (reported_cnt < MAX_SPAN) reported_cnt++;
    end
    if (f) begin
      pending_cnt = 0;
      reported_cnt = 0;
    end
    return n;
  endfunction

  // directed table rows
  function automatic step_t note_step(input logic [SB-1:0] p, o, r, input logic f);
    step_t s;
    s = '0;
    s.kind = STEP_NOTE;
    s.pitch = p;
    s.onset = o;
    s.rest = r;
    s.final_note = f;
    return s;
  endfunction

  function automatic step_t mark_step(input logic [SB-1:0] p, o, r, input logic f,
                                      input logic [SB:0] c, input logic b, l);
    step_t s;
    s = note_step(p, o, r, f);
    s.has_mark = 1'b1;
    s.mark = '{c, b, l};
    return s;
  endfunction

  function automatic step_t write_step(input wbpp_pkg::cfg_reg_t idx,
                                       input logic [wbpp_pkg::CFG_W-1:0] val);
    step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.value = val;
    return s;
  endfunction

  function automatic logic [wbpp_pkg::CFG_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return wbpp_pkg::CFG_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // full range, a few repeated levels for plateaus, or tiny values for ties
  function automatic logic [SB-1:0] pick_strength(input int mode);
    case (mode)
      0: return SB'($urandom_range(0, 16'hFFFF));
      1: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return 16'h8000;
        endcase
      end
      default: return SB'($urandom_range(0, 3));
    endcase
  endfunction

  // offer one word and hold it until taken; valid stays up for the caller
  task automatic send_note(input logic [SB-1:0] p, o, r, input logic f, output int released);
    in_valid <= 1'b1;
    in_pitch_strength <= p;
    in_onset_strength <= o;
    in_rest_strength <= r;
    in_final_note <= f;
    do @(posedge clk); while (!in_ready);
    released = predict_marks(p, o, r, f);
    notes_sent++;
    if (f) parts_closed++;
    settled = 1'b0;
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every predicted word, then let a silent word finish
  task automatic drain_results();
    if (!settled) begin
      in_valid <= 1'b0;
      while (awaited_marks.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      settled = 1'b1;
    end
  endtask

  task automatic write_reg(input wbpp_pkg::cfg_reg_t idx,
                           input logic [wbpp_pkg::CFG_W-1:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_write(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
    writes_done++;
  endtask

  // stimulus
  initial begin : stimulus
    int                         released, rand_notes, parts, pi, len, k, mode, span_pick, i;
    bit                         open_end;
    logic [wbpp_pkg::CFG_W-1:0] span_word;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pitch_strength <= '0;
    in_onset_strength <= '0;
    in_rest_strength <= '0;
    in_final_note <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    for (i = 0; i < WIN_DEPTH; i++) win_vals[i] = '0;

    // defaults after reset: a lone final position is its own boundary
    add_step(mark_step('1, '1, '1, 1'b1, 17'd32767, 1'b1, 1'b1));
    add_step(mark_step('0, '0, '0, 1'b1, 17'd0, 1'b1, 1'b1));
    // full-scale weights and span zero: each position reported at once
    add_step(write_step(wbpp_pkg::REG_WEIGHT_ONSET, 16'hFFFF));
    add_step(write_step(wbpp_pkg::REG_WEIGHT_PITCH, 16'hFFFF));
    add_step(write_step(wbpp_pkg::REG_WEIGHT_REST, 16'hFFFF));
    add_step(write_step(wbpp_pkg::REG_WINDOW_SPAN, 16'h0000));
    add_step(mark_step('1, '1, '1, 1'b0, 17'd98301, 1'b1, 1'b0));
    add_step(mark_step('0, '0, '0, 1'b0, 17'd0, 1'b1, 1'b0));
    add_step(mark_step('1, '0, '0, 1'b1, 17'd32767, 1'b1, 1'b1));
    // zero weight drops its strength entirely
    add_step(write_step(wbpp_pkg::REG_WEIGHT_ONSET, 16'h0000));
    add_step(mark_step('0, '1, '0, 1'b0, 17'd0, 1'b1, 1'b0));
    // span above the maximum acts as the maximum; plateaus and ramps
    add_step(write_step(wbpp_pkg::REG_WEIGHT_ONSET, 16'd40000));
    add_step(write_step(wbpp_pkg::REG_WEIGHT_PITCH, 16'd20000));
    add_step(write_step(wbpp_pkg::REG_WEIGHT_REST, 16'd5000));
    add_step(write_step(wbpp_pkg::REG_WINDOW_SPAN, 16'h000F));
    add_step(note_step(16'd100, 16'd200, 16'd300, 1'b0));
    add_step(note_step(16'd9000, 16'd9000, 16'd9000, 1'b0));
    add_step(note_step(16'd9000, 16'd9000, 16'd9000, 1'b0));
    add_step(note_step(16'd50, 16'd60, 16'd70, 1'b0));
    add_step(note_step('1, '1, '1, 1'b0));
    add_step(note_step('0, '0, '0, 1'b0));
    add_step(note_step('0, '0, '0, 1'b0));
    add_step(note_step(16'd1234, 16'd4321, 16'd777, 1'b0));
    add_step(note_step(16'd9000, 16'd9000, 16'd9000, 1'b0));
    add_step(note_step(16'd8000, 16'd8000, 16'd8000, 1'b1));
    // upper bits of the span word are ignored: this is span two
    add_step(write_step(wbpp_pkg::REG_WINDOW_SPAN, 16'hFFF2));
    add_step(note_step(16'd300, 16'd100, 16'd50, 1'b0));
    add_step(note_step(16'd700, 16'd900, 16'd20, 1'b0));
    add_step(note_step(16'd10, 16'd10, 16'd10, 1'b0));
    add_step(note_step(16'd4000, 16'd4000, 16'd400, 1'b0));
    add_step(note_step(16'd4000, 16'd4000, 16'd400, 1'b0));
    add_step(note_step(16'd2, 16'd3, 16'd4, 1'b0));
    // span shrunk with positions still pending, then closed by a final word
    add_step(write_step(wbpp_pkg::REG_WINDOW_SPAN, 16'h0001));
    add_step(note_step(16'd5000, 16'd6000, 16'd7000, 1'b0));
    add_step(note_step(16'd5000, 16'd6000, 16'd7000, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_note(plan[i].pitch, plan[i].onset, plan[i].rest, plan[i].final_note, released);
        // rows read off by hand replace what the predictor queued for them
        if (plan[i].has_mark) begin
          repeat (released) void'(awaited_marks.pop_back());
          enqueue_mark(plan[i].mark);
        end
      end
    end

    // random phases: fresh settings, then whole parts with random content
    rand_notes = 0;
    while (rand_notes < RANDOM_NOTES) begin
      if ($urandom_range(0, 1)) write_reg(wbpp_pkg::REG_WEIGHT_ONSET, pick_weight());
      if ($urandom_range(0, 1)) write_reg(wbpp_pkg::REG_WEIGHT_PITCH, pick_weight());
      if ($urandom_range(0, 1)) write_reg(wbpp_pkg::REG_WEIGHT_REST, pick_weight());
      span_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      span_word = wbpp_pkg::CFG_W'($urandom_range(0, 16'hFFFF));
      span_word[wbpp_pkg::SPAN_W-1:0] = span_pick[wbpp_pkg::SPAN_W-1:0];
      write_reg(wbpp_pkg::REG_WINDOW_SPAN, span_word);

      parts = $urandom_range(1, 3);
      for (pi = 0; pi < parts; pi++) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 12);
        if (len > RANDOM_NOTES - rand_notes) len = RANDOM_NOTES - rand_notes;
        mode = $urandom_range(0, 2);
        // now and then a phase stops mid-part so the next span lands on it
        open_end = (pi == parts - 1) && ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++) begin
          if (!calm && !long_hold_req && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 5));
          send_note(pick_strength(mode), pick_strength(mode), pick_strength(mode),
                    (k == len - 1) && !open_end, released);
          rand_notes++;
          // one long receiver hold-off while words keep coming
          if (rand_notes == 60) long_hold_req = 1'b1;
          if (rand_notes >= RANDOM_NOTES - CALM_NOTES) calm = 1'b1;
        end
      end
    end

    // wind down
    in_valid <= 1'b0;
    while (awaited_marks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d note words in %0d closed parts, checked %0d results, %0d reg writes",
             notes_sent, parts_closed, marks_checked, writes_done);
    $display("Spans from zero to above the limit, zero and full-scale weights, both sides stalled");
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // compare one result word with the oldest prediction
  function automatic void check_mark();
    mark_t want;
    if (awaited_marks.size() == 0) begin
      $error("result with nothing predicted: combined_strength %0d", out_combined_strength);
      err_cnt++;
      return;
    end
    want = awaited_marks.pop_front();
    if (out_combined_strength !== want.strength) begin
      $error("combined_strength: expected %0d, got %0d", want.strength, out_combined_strength);
      err_cnt++;
    end
    if (out_is_boundary !== want.boundary) begin
      $error("is_boundary: expected %0b, got %0b", want.boundary, out_is_boundary);
      err_cnt++;
    end
    if (out_last_of_part !== want.last) begin
      $error("last_of_part: expected %0b, got %0b", want.last, out_last_of_part);
      err_cnt++;
    end
    marks_checked++;
  endfunction

  // result side: random stall bursts, one long hold-off, none near the end
  initial begin : result_sink
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_mark();
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) long_hold_req = 1'b0;
        out_ready <= (hold_left == 0);
      end else if (long_hold_req) begin
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= (stall_left == 0);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/wbpp_pkg.sv
rtl/core/wbpp_ram.sv
rtl/core/wbpp_mac.sv
rtl/core/wbpp_cmp.sv
rtl/core/weighted_boundary_peak_picker_top.sv
rtl/core/wbpp_checker.sv
test/weighted_boundary_peak_picker_top_tb.sv
